>>> rtl/cac_pkg.sv
package cac_pkg;

  localparam logic [15:0] POS_FULL         = 16'hFFFF;
  localparam logic [15:0] POS_HALF         = 16'h8000;
  localparam logic [15:0] OPEN_THRESHOLD   = 16'd65470;
  localparam logic [15:0] CLOSED_THRESHOLD = 16'd66;

  localparam logic [23:0] TRAVEL_RATE_RST  = 24'd1678;
  localparam logic [31:0] TIMEOUT_RST      = 32'd30000;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_TRAVEL_RATE    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TRAVEL_TIMEOUT = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OPEN_PRESENT   = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CLOSED_PRESENT = 8'd3;

  localparam logic signed [1:0] DRIVE_OFF   = 2'sb00;
  localparam logic signed [1:0] DRIVE_OPEN  = 2'sb01;
  localparam logic signed [1:0] DRIVE_CLOSE = 2'sb11;

  typedef enum logic [2:0] {
    ACT_TICK        = 3'd0,
    ACT_OPEN        = 3'd1,
    ACT_CLOSE       = 3'd2,
    ACT_STOP        = 3'd3,
    ACT_CLEAR_FAULT = 3'd4,
    ACT_SET_POS     = 3'd5
  } action_t;

  typedef struct packed {
    logic [23:0] travel_rate;
    logic [31:0] travel_timeout_ms;
    logic        open_sensor_present;
    logic        closed_sensor_present;
  } cfg_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] elapsed_ms;
    logic        open_reading_valid;
    logic        open_reading_hit;
    logic        closed_reading_valid;
    logic        closed_reading_hit;
    logic [15:0] new_position;
  } item_t;

  typedef struct packed {
    logic              moving;
    logic              is_closed;
    logic              is_open;
    logic              fault;
    logic [15:0]       cover_position;
    logic signed [1:0] drive;
  } result_t;

endpackage

>>> rtl/cover_actuator_controller_top.sv
// Cover actuator controller.
// s_axis carries one action per transfer (tick, open, close, stop, clear fault,
// set position); m_axis returns exactly one status word per action, in order.
// cfg_* writes the travel rate, travel timeout and sensor-present bits; the
// port is always ready and should be written only while no action is in flight.
// Each action sits in an input register; the combinational state update feeds
// the status register, which drives m_axis_tvalid. One action per cycle is
// sustained while m_axis_tready stays high; the longest path runs from the
// input register through a single 24x16 multiply plus add/clamp.
// When m_axis stalls the status register holds; the input register takes one
// more action if it is empty, then s_axis_tready drops until the status word
// is taken.
// Reset (rst, synchronous) clears position and target to closed, travel time,
// fault and limit latches, drive off, and loads the default configuration.
module cover_actuator_controller_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] elapsed_ms, [16] open_reading_valid, [17] open_reading_hit,
  // [18] closed_reading_valid, [19] closed_reading_hit, [35:20] new_position
  input  logic [39:0] s_axis_tdata,
  // [2:0] action
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] drive, [17:2] cover_position, [18] fault, [19] is_open,
  // [20] is_closed, [21] moving
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cac_pkg::cfg_t    cfg;
  cac_pkg::item_t   in_item;
  cac_pkg::item_t   in_item_next;
  cac_pkg::result_t result;
  logic             in_full;
  logic             out_valid;
  logic [21:0]      out_data;
  logic             fire;

  assign cfg_ready = 1'b1;

  cac_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign fire          = in_full && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_full || fire;

  always_comb begin
    in_item_next.action               = cac_pkg::action_t'(s_axis_tuser);
    in_item_next.elapsed_ms           = s_axis_tdata[15:0];
    in_item_next.open_reading_valid   = s_axis_tdata[16];
    in_item_next.open_reading_hit     = s_axis_tdata[17];
    in_item_next.closed_reading_valid = s_axis_tdata[18];
    in_item_next.closed_reading_hit   = s_axis_tdata[19];
    in_item_next.new_position         = s_axis_tdata[35:20];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= in_item_next;
    end
  end

  cac_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_data};

endmodule

>>> rtl/cac_cfg.sv
module cac_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [cac_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  logic [cac_pkg::CFG_DATA_W-1:0]   wr_data,
  output cac_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.travel_rate           <= cac_pkg::TRAVEL_RATE_RST;
      cfg.travel_timeout_ms     <= cac_pkg::TIMEOUT_RST;
      cfg.open_sensor_present   <= 1'b0;
      cfg.closed_sensor_present <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        cac_pkg::REG_TRAVEL_RATE:    cfg.travel_rate           <= wr_data[23:0];
        cac_pkg::REG_TRAVEL_TIMEOUT: cfg.travel_timeout_ms     <= wr_data;
        cac_pkg::REG_OPEN_PRESENT:   cfg.open_sensor_present   <= wr_data[0];
        cac_pkg::REG_CLOSED_PRESENT: cfg.closed_sensor_present <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/cac_core.sv
module cac_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  cac_pkg::item_t   item,
  input  cac_pkg::cfg_t    cfg,
  output cac_pkg::result_t result
);

  logic [15:0]       position;
  logic [15:0]       target;
  logic [31:0]       travel_time;
  logic              fault_flag;
  logic              open_latched;
  logic              closed_latched;
  logic signed [1:0] drive;

  logic [15:0]       position_next;
  logic [15:0]       target_next;
  logic [31:0]       travel_time_next;
  logic              fault_flag_next;
  logic              open_latched_next;
  logic              closed_latched_next;
  logic signed [1:0] drive_next;

  logic        ol;
  logic        cl;
  logic [15:0] pos_snap;
  logic        opening;
  logic        reached_snap;
  logic [32:0] tt_sum;
  logic [31:0] tt_sat;
  logic [39:0] product;
  logic [31:0] step;
  logic [16:0] pos_add;
  logic [15:0] pos_moved;
  logic        reached_moved;

  assign ol = (cfg.open_sensor_present && item.open_reading_valid)
              ? item.open_reading_hit : open_latched;
  assign cl = (cfg.closed_sensor_present && item.closed_reading_valid)
              ? item.closed_reading_hit : closed_latched;

  // closed limit wins since it is checked first
  assign pos_snap = cl ? 16'd0 : (ol ? cac_pkg::POS_FULL : position);
  assign opening  = target > cac_pkg::POS_HALF;

  assign reached_snap = opening
      ? (cfg.open_sensor_present ? ol : (pos_snap >= cac_pkg::OPEN_THRESHOLD))
      : (cfg.closed_sensor_present ? cl : (pos_snap <= cac_pkg::CLOSED_THRESHOLD));

  assign tt_sum = {1'b0, travel_time} + {17'd0, item.elapsed_ms};
  assign tt_sat = tt_sum[32] ? 32'hFFFF_FFFF : tt_sum[31:0];

  assign product = 40'(cfg.travel_rate) * 40'(item.elapsed_ms);
  assign step    = product[39:8];
  assign pos_add = {1'b0, pos_snap} + {1'b0, step[15:0]};

  always_comb begin
    if (opening) begin
      pos_moved = ((|step[31:16]) || pos_add[16]) ? cac_pkg::POS_FULL : pos_add[15:0];
    end else begin
      pos_moved = (step >= {16'd0, pos_snap}) ? 16'd0 : (pos_snap - step[15:0]);
    end
  end

  // only used with both sensors absent, so the thresholds apply
  assign reached_moved = opening ? (pos_moved >= cac_pkg::OPEN_THRESHOLD)
                                 : (pos_moved <= cac_pkg::CLOSED_THRESHOLD);

  always_comb begin
    position_next       = position;
    target_next         = target;
    travel_time_next    = travel_time;
    fault_flag_next     = fault_flag;
    open_latched_next   = open_latched;
    closed_latched_next = closed_latched;
    drive_next          = drive;
    case (item.action)
      cac_pkg::ACT_TICK: begin
        open_latched_next   = ol;
        closed_latched_next = cl;
        if (ol && cl) begin
          fault_flag_next = 1'b1;
          drive_next      = cac_pkg::DRIVE_OFF;
        end else begin
          position_next = pos_snap;
          if (fault_flag || reached_snap) begin
            travel_time_next = 32'd0;
            drive_next       = cac_pkg::DRIVE_OFF;
          end else begin
            travel_time_next = tt_sat;
            if ((cfg.travel_timeout_ms != 32'd0) && (tt_sat >= cfg.travel_timeout_ms)) begin
              fault_flag_next = 1'b1;
              drive_next      = cac_pkg::DRIVE_OFF;
            end else begin
              position_next = pos_moved;
              drive_next    = opening ? cac_pkg::DRIVE_OPEN : cac_pkg::DRIVE_CLOSE;
              if (!cfg.open_sensor_present && !cfg.closed_sensor_present && reached_moved) begin
                travel_time_next = 32'd0;
                drive_next       = cac_pkg::DRIVE_OFF;
              end
            end
          end
        end
      end
      cac_pkg::ACT_OPEN: begin
        if (target != cac_pkg::POS_FULL) travel_time_next = 32'd0;
        target_next = cac_pkg::POS_FULL;
      end
      cac_pkg::ACT_CLOSE: begin
        if (target != 16'd0) travel_time_next = 32'd0;
        target_next = 16'd0;
      end
      cac_pkg::ACT_STOP: begin
        target_next      = position;
        travel_time_next = 32'd0;
        drive_next       = cac_pkg::DRIVE_OFF;
      end
      cac_pkg::ACT_CLEAR_FAULT: begin
        fault_flag_next  = 1'b0;
        travel_time_next = 32'd0;
      end
      cac_pkg::ACT_SET_POS: begin
        position_next = item.new_position;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position       <= 16'd0;
      target         <= 16'd0;
      travel_time    <= 32'd0;
      fault_flag     <= 1'b0;
      open_latched   <= 1'b0;
      closed_latched <= 1'b0;
      drive          <= cac_pkg::DRIVE_OFF;
    end else if (fire) begin
      position       <= position_next;
      target         <= target_next;
      travel_time    <= travel_time_next;
      fault_flag     <= fault_flag_next;
      open_latched   <= open_latched_next;
      closed_latched <= closed_latched_next;
      drive          <= drive_next;
    end
  end

  always_comb begin
    result.drive          = drive_next;
    result.cover_position = position_next;
    result.fault          = fault_flag_next;
    result.is_open        = cfg.open_sensor_present ? open_latched_next
                            : (position_next >= cac_pkg::OPEN_THRESHOLD);
    result.is_closed      = cfg.closed_sensor_present ? closed_latched_next
                            : (position_next <= cac_pkg::CLOSED_THRESHOLD);
    result.moving         = (position_next != target_next) || (drive_next != cac_pkg::DRIVE_OFF);
  end

endmodule

>>> rtl/cac_checker.sv
module cac_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("status word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("status valid right after reset");

  a_fault_off: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[18] |-> m_axis_tdata[1:0] == 2'b00)
    else $error("drive active while faulted");

  a_drive_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'b10)
    else $error("illegal drive code");

  a_drive_moving: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] != 2'b00 |-> m_axis_tdata[21])
    else $error("drive active but not moving");

endmodule

bind cover_actuator_controller_top cac_checker u_cac_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
